>>> rtl/core/paewf_pkg.sv
// ----------------------------------------------------------------------------
// paewf_pkg
// Shared types and codes of the page allocator: sequencer states, request
// modes, status codes and the fixed widths of the transaction fields.
// ----------------------------------------------------------------------------
package paewf_pkg;

  // Fixed field widths of the transaction ports
  localparam int unsigned REQ_W    = 11;  // request_pages, stored run length
  localparam int unsigned PAGE_W   = 10;  // page_index, result_page, first_page
  localparam int unsigned BRK_W    = 11;  // break_after
  localparam int unsigned STATUS_W = 3;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BADSIZE = 3'd2;
  localparam logic [STATUS_W-1:0] STS_OUTSIDE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DOUBLE  = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,     // post-reset sweep that zeroes the run length table
    S_IDLE,      // waiting for a transaction
    S_FREE_CHK,  // free: examine the entry read at the given page
    S_SCAN       // walk the table from page zero up to the break
  } state_e;

endpackage

>>> rtl/core/page_allocator_exact_worst_fit.sv
// ----------------------------------------------------------------------------
// page_allocator_exact_worst_fit
// Page-granular heap allocator: exact fit, then worst fit, then break growth.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start while busy is low; mode_i selects
//   allocate or free, request_pages_i and page_index_i carry the operands.
//   Exactly one result follows, shown for a single cycle with done_o high
//   (status_o, result_page_o, break_after_o). The receiver cannot stall, so
//   the result must be captured in that cycle.
//   The run length table sits in a single synchronous RAM with one write and
//   one read port; the walk over it reads one page per cycle, so the page
//   walk sets the item time:
//     - bad size / outside region: result in the cycle after acceptance
//     - allocate: a walk from page zero up to the break, ended early on an
//       exact-fit hit
//     - free: a check of the entry, then a walk when the break shrinks
//   Transactions are handled one at a time.
//   After reset the block runs a clearing pass over the table with busy high;
//   first_page writes are taken during that pass.
//   Write first_page only while idle; the write also moves the break to it.
// ----------------------------------------------------------------------------
module page_allocator_exact_worst_fit
  import paewf_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [PAGE_W-1:0]   first_page_i,
  // request transaction
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [REQ_W-1:0]    request_pages_i,
  input  logic [PAGE_W-1:0]   page_index_i,
  // result transaction
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [PAGE_W-1:0]   result_page_o,
  output logic [BRK_W-1:0]    break_after_o
);

  // page index width, page count width (holds NUM_PAGES), and a working
  // width wide enough for page + run length without overflow
  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned XW = (CW > 12) ? CW + 1 : 13;

  localparam logic [XW-1:0] NUM_X     = XW'(NUM_PAGES);
  localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);

  // --------------------------------------------------------------------------
  // Run length table: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [REQ_W-1:0] mem [NUM_PAGES];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [REQ_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [REQ_W-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;     // clearing pass pointer
  logic [CW-1:0]       first_q, first_d; // first page of the region
  logic [CW-1:0]       brk_q, brk_d;     // break page
  logic                op_q, op_d;       // mode of the transaction in flight
  logic [REQ_W-1:0]    req_q, req_d;
  logic [AW-1:0]       pg_q, pg_d;
  logic [CW-1:0]       ra_q, ra_d;       // next page to read in the walk
  logic                dv_q, dv_d;       // read data of page pp_q is valid
  logic [AW-1:0]       pp_q, pp_d;
  logic [XW-1:0]       cov_q, cov_d;     // highest page reached by a run + 1
  logic [CW-1:0]       hl_q, hl_d;       // current hole length
  logic [AW-1:0]       hs_q, hs_d;       // current hole start
  logic                hb_q, hb_d;       // a best hole exists
  logic [CW-1:0]       bl_q, bl_d;       // best hole length
  logic [AW-1:0]       bs_q, bs_d;       // best hole start
  logic [CW-1:0]       nb_q, nb_d;       // new break during a shrink walk
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0]       result_q, result_d;
  logic [CW-1:0]       bo_q, bo_d;       // break after the transaction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      first_q <= '0;
      brk_q   <= '0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      first_q <= first_d;
      brk_q   <= brk_d;
      dv_q    <= dv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    req_q    <= req_d;
    pg_q     <= pg_d;
    ra_q     <= ra_d;
    pp_q     <= pp_d;
    cov_q    <= cov_d;
    hl_q     <= hl_d;
    hs_q     <= hs_d;
    hb_q     <= hb_d;
    bl_q     <= bl_d;
    bs_q     <= bs_d;
    nb_q     <= nb_d;
    status_q <= status_d;
    result_q <= result_d;
    bo_q     <= bo_d;
  end

  // --------------------------------------------------------------------------
  // Widened views for compares and sums
  // --------------------------------------------------------------------------
  logic [XW-1:0] req_in_x, pg_in_x, first_x, brk_x, req_x, pg_x, pp_x, ent_x;
  logic [XW-1:0] reach_x, cfg_x, cfg_sat_x, grow_x, res_x, bo_x;
  logic          is_free, in_region, h_eq, h_better;

  assign req_in_x  = XW'(request_pages_i);
  assign pg_in_x   = XW'(page_index_i);
  assign first_x   = XW'(first_q);
  assign brk_x     = XW'(brk_q);
  assign req_x     = XW'(req_q);
  assign pg_x      = XW'(pg_q);
  assign pp_x      = XW'(pp_q);
  assign ent_x     = XW'(mem_rdata_q);
  assign reach_x   = pp_x + ent_x;
  assign grow_x    = brk_x + req_x;
  assign cfg_x     = XW'(first_page_i);
  assign cfg_sat_x = (cfg_x > NUM_X) ? NUM_X : cfg_x;

  // page under examination is free when it starts no run and no earlier
  // run reaches over it
  assign is_free   = (mem_rdata_q == '0) && (cov_q <= pp_x);
  assign in_region = (pp_x >= first_x);

  // closing the current hole: exact fit, or a new largest hole
  assign h_eq     = (XW'(hl_q) == req_x);
  assign h_better = (XW'(hl_q) > req_x) && (!hb_q || (hl_q > bl_q));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    logic          grant;
    logic [AW-1:0] grant_page;
    logic          respond;
    logic [STATUS_W-1:0] resp_status;

    grant       = 1'b0;
    grant_page  = '0;
    respond     = 1'b0;
    resp_status = STS_OK;

    state_d  = state_q;
    clr_d    = clr_q;
    first_d  = first_q;
    brk_d    = brk_q;
    op_d     = op_q;
    req_d    = req_q;
    pg_d     = pg_q;
    ra_d     = ra_q;
    dv_d     = 1'b0;
    pp_d     = ra_q[AW-1:0];
    cov_d    = cov_q;
    hl_d     = hl_q;
    hs_d     = hs_q;
    hb_d     = hb_q;
    bl_d     = bl_q;
    bs_d     = bs_q;
    nb_d     = nb_q;
    done_d   = 1'b0;
    status_d = status_q;
    result_d = result_q;
    bo_d     = bo_q;

    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = ra_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        // zero one entry per cycle
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_PAGE) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d  = mode_i;
          req_d = request_pages_i;
          pg_d  = pg_in_x[AW-1:0];
          if (mode_i == MODE_ALLOC) begin
            if ((request_pages_i == '0) || (req_in_x > NUM_X)) begin
              respond     = 1'b1;
              resp_status = STS_BADSIZE;
            end else begin
              ra_d    = '0;
              cov_d   = '0;
              hl_d    = '0;
              hb_d    = 1'b0;
              state_d = S_SCAN;
            end
          end else if ((pg_in_x < first_x) || (pg_in_x >= NUM_X)) begin
            respond     = 1'b1;
            resp_status = STS_OUTSIDE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pg_in_x[AW-1:0];
            state_d   = S_FREE_CHK;
          end
        end
      end

      S_FREE_CHK: begin
        if (mem_rdata_q == '0) begin
          respond     = 1'b1;
          resp_status = STS_DOUBLE;
        end else begin
          // drop the run; the shrink walk reads after this write lands
          mem_we    = 1'b1;
          mem_waddr = pg_q;
          if (pg_x + ent_x == brk_x) begin
            ra_d    = '0;
            cov_d   = '0;
            nb_d    = first_q;
            state_d = S_SCAN;
          end else begin
            respond = 1'b1;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle up to the break
        if (ra_q < brk_q) begin
          mem_re = 1'b1;
          ra_d   = ra_q + 1'b1;
          dv_d   = 1'b1;
        end

        if (dv_q) begin
          cov_d = (reach_x > cov_q) ? reach_x : cov_q;
          if (op_q == MODE_ALLOC) begin
            if (in_region) begin
              if (is_free) begin
                if (hl_q == '0) begin
                  hs_d = pp_q;
                end
                hl_d = hl_q + 1'b1;
              end else begin
                if (h_eq) begin
                  grant      = 1'b1;
                  grant_page = hs_q;
                end else if (h_better) begin
                  hb_d = 1'b1;
                  bl_d = hl_q;
                  bs_d = hs_q;
                end
                hl_d = '0;
              end
            end
          end else if (in_region && !is_free) begin
            nb_d = CW'(pp_x + XW'(1));
          end
        end else if (ra_q >= brk_q) begin
          // walk finished
          if (op_q == MODE_ALLOC) begin
            if (h_eq || h_better) begin
              grant      = 1'b1;
              grant_page = hs_q;
            end else if (hb_q) begin
              grant      = 1'b1;
              grant_page = bs_q;
            end else if (grow_x > NUM_X) begin
              respond     = 1'b1;
              resp_status = STS_NOSPACE;
            end else begin
              grant      = 1'b1;
              grant_page = brk_q[AW-1:0];
              brk_d      = grow_x[CW-1:0];
            end
          end else begin
            brk_d   = nb_q;
            respond = 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // record the granted run at its start page
    if (grant) begin
      mem_we    = 1'b1;
      mem_waddr = grant_page;
      mem_wdata = req_q;
    end

    if (grant || respond) begin
      state_d  = S_IDLE;
      done_d   = 1'b1;
      status_d = grant ? STS_OK : resp_status;
      result_d = grant ? grant_page : '0;
      bo_d     = brk_d;
    end

    // region base write also moves the break
    if (cfg_we_i) begin
      first_d = cfg_sat_x[CW-1:0];
      brk_d   = cfg_sat_x[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign res_x = XW'(result_q);
  assign bo_x  = XW'(bo_q);

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_page_o = res_x[PAGE_W-1:0];
  assign break_after_o = bo_x[BRK_W-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_break_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (brk_q >= first_q) && (XW'(brk_q) <= NUM_X))
    else $error("break left the page region");

  a_grant_reports_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (mem_wdata != '0)) |=> (done_o && (status_o == STS_OK)))
    else $error("run recorded without an ok result");

  a_fail_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STS_OK)) |-> (result_page_o == '0))
    else $error("failed transaction returned a page");

  a_scan_not_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !done_o)
    else $error("result produced during clearing pass");

endmodule
